// ===== hdl/fsu_pkg.sv =====
// Shared constants and types of the filterbank sample unpacker.
package fsu_pkg;

	localparam int MAX_CHANNELS = 4096;
	localparam int BANK_BYTES = 4 * MAX_CHANNELS;
	localparam int MEM_DEPTH = 2 * BANK_BYTES;
	localparam int POS_W = $clog2(BANK_BYTES);
	localparam int MEM_AW = POS_W + 1;
	localparam int CH_W = 12;
	localparam int CNT_W = 13;
	localparam int CFG_W = 13;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_CHANNELS = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIGNED = 2'd2;

	typedef enum logic [2:0] {
		WIDTH_1,
		WIDTH_2,
		WIDTH_4,
		WIDTH_8,
		WIDTH_16,
		WIDTH_FLOAT
	} width_code_t;

	typedef struct packed {
		logic emit;
		width_code_t code;
		logic sgn;
		logic [CH_W-1:0] ch_base;
		logic [2:0] last_k;
	} fsu_item_t;

	typedef struct packed {
		logic pass;
		logic neg;
		logic [31:0] word;
		logic [CH_W-1:0] channel;
		logic spec_end;
		logic last;
	} fsu_rec_t;

endpackage

// ===== hdl/fsu_bank_ram.sv =====
// Two spectrum banks in one synchronous RAM with one write and one read port.
module fsu_bank_ram import fsu_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [MEM_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [MEM_AW-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/fsu_unpack.sv =====
// Sample emitter: splits a stored byte into samples and assembles wide samples.
module fsu_unpack import fsu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  fsu_item_t       item,
	input  logic [7:0]      rdata,
	input  logic [CH_W-1:0] nm1,
	output logic            item_take,
	output logic            rec_valid,
	output fsu_rec_t        rec,
	input  logic            rec_ready
);

	logic            em_valid_q;
	width_code_t     em_code_q;
	logic            em_signed_q;
	logic [2:0]      em_k_q;
	logic [2:0]      em_last_k_q;
	logic [CH_W-1:0] em_ch_q;
	logic [7:0]      sh_q;
	logic [31:0]     acc_q;
	logic            at_last;
	logic            free;

	assign at_last = (em_k_q == em_last_k_q);
	assign free = !em_valid_q || (rec_ready && at_last);
	assign item_take = item_valid && free;
	assign rec_valid = em_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
		end else if (item_take) begin
			em_valid_q <= item.emit;
		end else if (free) begin
			em_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			em_code_q <= item.code;
			em_signed_q <= item.sgn;
			em_k_q <= 3'd0;
			em_last_k_q <= item.last_k;
			em_ch_q <= item.ch_base;
			sh_q <= rdata;
			acc_q <= {rdata, acc_q[31:8]};
		end else if (em_valid_q && rec_ready) begin
			em_k_q <= em_k_q + 3'd1;
			em_ch_q <= em_ch_q + CH_W'(1);
			case (em_code_q)
				WIDTH_1: sh_q <= {sh_q[6:0], 1'b0};
				WIDTH_2: sh_q <= {sh_q[5:0], 2'b0};
				WIDTH_4: sh_q <= {sh_q[3:0], 4'b0};
				default: sh_q <= sh_q;
			endcase
		end
	end

	always_comb begin
		rec.pass = 1'b0;
		rec.neg = 1'b0;
		rec.word = 32'd0;
		rec.channel = em_ch_q;
		rec.spec_end = (em_ch_q == nm1);
		rec.last = at_last;
		case (em_code_q)
			WIDTH_1: rec.word = {31'd0, sh_q[7]};
			WIDTH_2: rec.word = {30'd0, sh_q[7:6]};
			WIDTH_4: rec.word = {28'd0, sh_q[7:4]};
			WIDTH_8: begin
				if (em_signed_q && sh_q[7]) begin
					rec.neg = 1'b1;
					rec.word = {24'd0, ~sh_q} + 32'd1;
				end else begin
					rec.word = {24'd0, sh_q};
				end
			end
			WIDTH_16: rec.word = {16'd0, acc_q[31:16]};
			default: begin
				rec.pass = 1'b1;
				rec.word = acc_q;
			end
		endcase
	end

endmodule

// ===== hdl/fsu_float_out.sv =====
// Integer to IEEE single conversion and the registered result port.
module fsu_float_out import fsu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rec_valid,
	input  fsu_rec_t        rec,
	output logic            rec_ready,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     sample_value,
	output logic [CH_W-1:0] channel_index,
	output logic            spectrum_end,
	output logic            run_last
);

	logic            valid_s2;
	fsu_rec_t        rec_s2;
	logic            out_valid_q;
	logic [31:0]     value_q;
	logic [CH_W-1:0] channel_q;
	logic            end_q;
	logic            last_q;
	logic            out_load;
	logic [15:0]     mag;
	logic [3:0]      msb;
	logic [15:0]     norm;
	logic [7:0]      expo;
	logic [31:0]     value;

	assign out_load = !out_valid_q || !out_stall;
	assign rec_ready = !valid_s2 || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_ready) begin
				valid_s2 <= rec_valid;
			end
			if (out_load) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			rec_s2 <= rec;
		end
		if (out_load && valid_s2) begin
			value_q <= value;
			channel_q <= rec_s2.channel;
			end_q <= rec_s2.spec_end;
			last_q <= rec_s2.last;
		end
	end

	always_comb begin
		mag = rec_s2.word[15:0];
		msb = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag[i]) begin
				msb = 4'(i);
			end
		end
		norm = mag << (4'd15 - msb);
		expo = 8'd127 + {4'd0, msb};
		if (rec_s2.pass) begin
			value = rec_s2.word;
		end else if (mag == 16'd0) begin
			value = 32'd0;
		end else begin
			value = {rec_s2.neg, expo, norm[14:0], 8'd0};
		end
	end

	assign out_valid = out_valid_q;
	assign sample_value = value_q;
	assign channel_index = channel_q;
	assign spectrum_end = end_q;
	assign run_last = last_q;

endmodule

// ===== hdl/filterbank_sample_unpack_reverse.sv =====
// Top level of the filterbank sample unpacker with band reversal.
// Each accepted byte is written into the current bank while the byte of the same slot,
// mirrored across the band, is read from the other bank of one RAM with one write and one
// read port; a new byte is taken as the emitter hands on the last result of the previous
// one, or at once when it is idle. A byte gives eight results in 1-bit mode, four in 2-bit,
// two in 4-bit and one in 8-bit mode, and one on every second or fourth byte for 16-bit and
// float samples; the result port delivers one result per cycle while out_stall is low. The
// first result of a byte passes the RAM read register, the emitter register, the conversion
// register and the output register, and the others follow it. Nothing is given for the first
// spectrum after reset or after any register write, so the host follows the last spectrum
// with one dummy spectrum. The banks need no clearing after reset.
module filterbank_sample_unpack_reverse import fsu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      sample_value,
	output logic [CH_W-1:0]  channel_index,
	output logic             spectrum_end,
	output logic             run_last
);

	logic [2:0]       width_q;
	logic [CNT_W-1:0] channels_q;
	logic             signed_q;
	logic [POS_W-1:0] byte_position_q;
	logic             write_bank_q;
	logic             prev_valid_q;
	logic             valid_s1;
	fsu_item_t        item_s1;

	width_code_t      code;
	logic [CNT_W-1:0] n_eff;
	logic [CH_W-1:0]  nm1;
	logic [17:0]      nb_x;
	logic [POS_W:0]   nbytes;
	logic [POS_W-1:0] nbm1;
	logic [POS_W-1:0] rev;
	logic [POS_W-1:0] xmask;
	logic             cfg_hit;
	logic             in_acc;
	logic             item_take;
	fsu_item_t        item;
	logic [7:0]       rdata;
	logic             rec_valid;
	logic             rec_ready;
	fsu_rec_t         rec;

	assign code = (width_q > 3'(WIDTH_FLOAT)) ? WIDTH_FLOAT : width_code_t'(width_q);

	always_comb begin
		n_eff = {channels_q[CNT_W-1:3], 3'b000};
		if (n_eff < CNT_W'(8)) begin
			n_eff = CNT_W'(8);
		end else if (n_eff > CNT_W'(MAX_CHANNELS)) begin
			n_eff = CNT_W'(MAX_CHANNELS);
		end
	end

	assign nm1 = CH_W'(n_eff - CNT_W'(1));
	assign nb_x = 18'(n_eff) << code;
	assign nbytes = nb_x[POS_W+3:3];
	assign nbm1 = POS_W'(nbytes - (POS_W+1)'(1));
	assign rev = nbm1 - byte_position_q;

	always_comb begin
		case (code)
			WIDTH_16:    xmask = POS_W'(1);
			WIDTH_FLOAT: xmask = POS_W'(3);
			default:     xmask = '0;
		endcase
	end

	always_comb begin
		item.code = code;
		item.sgn = signed_q;
		item.emit = 1'b0;
		item.last_k = 3'd0;
		item.ch_base = CH_W'(byte_position_q);
		case (code)
			WIDTH_1: begin
				item.emit = prev_valid_q;
				item.last_k = 3'd7;
				item.ch_base = CH_W'(byte_position_q << 3);
			end
			WIDTH_2: begin
				item.emit = prev_valid_q;
				item.last_k = 3'd3;
				item.ch_base = CH_W'(byte_position_q << 2);
			end
			WIDTH_4: begin
				item.emit = prev_valid_q;
				item.last_k = 3'd1;
				item.ch_base = CH_W'(byte_position_q << 1);
			end
			WIDTH_8: begin
				item.emit = prev_valid_q;
			end
			WIDTH_16: begin
				item.emit = prev_valid_q && byte_position_q[0];
				item.ch_base = CH_W'(byte_position_q >> 1);
			end
			default: begin
				item.emit = prev_valid_q && (&byte_position_q[1:0]);
				item.ch_base = CH_W'(byte_position_q >> 2);
			end
		endcase
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_CHANNELS ||
		cfg_index == REG_SIGNED);
	assign in_stall = valid_s1 && !item_take;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 3'(WIDTH_8);
			channels_q <= CNT_W'(1024);
			signed_q <= 1'b0;
			byte_position_q <= '0;
			write_bank_q <= 1'b0;
			prev_valid_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !item_take);
			if (cfg_hit) begin
				case (cfg_index)
					REG_WIDTH:    width_q <= cfg_data[2:0];
					REG_CHANNELS: channels_q <= cfg_data;
					default:      signed_q <= cfg_data[0];
				endcase
				byte_position_q <= '0;
				prev_valid_q <= 1'b0;
			end else if (in_acc) begin
				if (byte_position_q == nbm1) begin
					byte_position_q <= '0;
					write_bank_q <= !write_bank_q;
					prev_valid_q <= 1'b1;
				end else begin
					byte_position_q <= byte_position_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item;
		end
	end

	fsu_bank_ram u_ram (
		.clk   (clk),
		.we    (in_acc),
		.waddr ({write_bank_q, byte_position_q}),
		.wdata (data_byte),
		.re    (in_acc),
		.raddr ({!write_bank_q, rev ^ xmask}),
		.rdata (rdata)
	);

	fsu_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.rdata      (rdata),
		.nm1        (nm1),
		.item_take  (item_take),
		.rec_valid  (rec_valid),
		.rec        (rec),
		.rec_ready  (rec_ready)
	);

	fsu_float_out u_float_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (rec_valid),
		.rec           (rec),
		.rec_ready     (rec_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_value  (sample_value),
		.channel_index (channel_index),
		.spectrum_end  (spectrum_end),
		.run_last      (run_last)
	);

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_position_q <= nbm1)
		else $error("Byte position beyond the end of the spectrum.");

	a_wrap_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !cfg_hit && byte_position_q == nbm1 |=> prev_valid_q && byte_position_q == '0)
		else $error("Spectrum wrap did not mark a held spectrum.");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel_index <= nm1)
		else $error("Result channel beyond the channel count.");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spectrum_end |-> run_last)
		else $error("Last channel of a spectrum is not the last result of its item.");

endmodule
